>>> sv/imu_bias_calibrate_scale_ring_unit_assert.svh
// Assertion macros for the IMU bias calibration ring unit
`ifndef IMU_BIAS_CALIBRATE_SCALE_RING_UNIT_ASSERT_SVH
`define IMU_BIAS_CALIBRATE_SCALE_RING_UNIT_ASSERT_SVH
// implication checked at every clock edge outside reset
`define IBC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// implication checked in the cycle after the antecedent
`define IBC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> sv/ibc_pkg.sv
// Shared types and constants for the IMU bias calibration ring unit
package ibc_pkg;
  localparam int unsigned MIN_CALIB_COUNT = 10;
  localparam logic [1:0] CFG_CALIB = 2'd0;
  localparam logic [1:0] CFG_ACCEL = 2'd1;
  localparam logic [1:0] CFG_GYRO  = 2'd2;

  typedef struct packed {
    logic        func;
    logic [47:0] stamp;
    logic signed [15:0] accel_x_raw;
    logic signed [15:0] accel_y_raw;
    logic signed [15:0] accel_z_raw;
    logic signed [15:0] gyro_x_raw;
    logic signed [15:0] gyro_y_raw;
    logic signed [15:0] gyro_z_raw;
    logic [47:0] window_start;
    logic [47:0] window_end;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic        last;
    logic [47:0] sample_time;
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
    logic signed [31:0] accel_z;
    logic signed [31:0] gyro_x;
    logic signed [31:0] gyro_y;
    logic signed [31:0] gyro_z;
  } out_item_t;

  // stored entry: time plus six scaled axes
  localparam int unsigned ENTRY_W = 48 + 6 * 32;

  typedef struct packed {
    logic load_in;     // capture the input transaction
    logic acc_add;     // add gyro into sums
    logic div_start;   // start bias division
    logic scale_step;  // compute one scaled axis
    logic ring_write;  // write the scaled entry
    logic rd_issue;    // issue a ring read at rd_idx
    logic res_load;    // load result register from read data
    logic res_empty;   // load a found=0 result
    logic res_last;    // mark loaded result last
  } ibc_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic rd_match;    // registered read entry matches the window
  } ibc_stat_t;
endpackage

>>> sv/ibc_if.sv
// Valid/ready channel interfaces
interface ibc_in_if;
  import ibc_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ibc_out_if;
  import ibc_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ibc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

>>> sv/ibc_ram.sv
// Generic single-port-write, registered-read RAM
module ibc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    // hold read data until the next read
    if (re) rdata <= mem[raddr];
  end
endmodule

>>> sv/ibc_div.sv
// Restoring divider: bias = round(|sum|*256 / count), signed result
module ibc_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [32:0] sum,
  input  logic [15:0]        cnt,
  output logic               busy,
  output logic signed [23:0] quo
);
  // numerator |sum|*256 + cnt/2 fits 42 bits
  logic [41:0] num_r, num_nxt;
  logic [41:0] q_r, q_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [15:0] den_r;
  logic        neg_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r;
  logic [32:0] mag;
  logic [16:0] trial;

  assign mag = sum[32] ? 33'(-sum) : sum;
  assign trial = {rem_r[15:0], num_r[41]};

  always_comb begin
    num_nxt = {num_r[40:0], 1'b0};
    rem_nxt = trial;
    q_nxt = {q_r[40:0], 1'b0};
    if (trial >= {1'b0, den_r}) begin
      rem_nxt = trial - {1'b0, den_r};
      q_nxt[0] = 1'b1;
    end
    cnt_nxt = cnt_r - 6'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r <= 6'd42;
    end else if (busy_r) begin
      cnt_r <= cnt_nxt;
      if (cnt_r == 6'd1) busy_r <= 1'b0;
    end
    if (start) begin
      num_r <= {1'b0, mag, 8'd0} + {26'd0, 1'b0, cnt[15:1]};
      den_r <= cnt;
      neg_r <= sum[32];
      q_r <= '0;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
      q_r <= q_nxt;
    end
  end

  assign busy = busy_r;
  assign quo = neg_r ? 24'(-q_r[23:0]) : q_r[23:0];
endmodule

>>> sv/ibc_datapath.sv
// Datapath: calibration sums, bias, scaling, ring storage and result register
module ibc_datapath #(
  parameter int RING_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ibc_pkg::ibc_cmd_t    cmd,
  input  logic [1:0]           div_axis,
  input  logic [2:0]           axis_sel,
  input  logic [$clog2(RING_DEPTH)-1:0] wr_idx,
  input  logic [$clog2(RING_DEPTH)-1:0] rd_idx,
  input  ibc_pkg::in_item_t    in_data,
  input  logic [15:0]          calib_seen,
  input  logic [15:0]          accel_scale,
  input  logic [15:0]          gyro_scale,
  output ibc_pkg::ibc_stat_t   stat,
  output ibc_pkg::out_item_t   res
);
  import ibc_pkg::*;
  localparam int AW = $clog2(RING_DEPTH);

  in_item_t           item_r;
  logic signed [32:0] sum_r [3];
  logic signed [23:0] bias_r [3];
  logic signed [31:0] scaled_r [6];
  logic               div_busy, div_busy_d;
  logic signed [23:0] div_q;
  logic signed [15:0] raw;
  logic signed [23:0] bsel;
  logic signed [24:0] diff;
  logic signed [16:0] fac;
  logic signed [41:0] prod;
  logic signed [41:0] rnd;
  logic [ENTRY_W-1:0] wentry, rentry;
  out_item_t          res_r;
  logic [47:0]        rtime;

  ibc_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .sum(sum_r[div_axis]),
    .cnt(calib_seen), .busy(div_busy), .quo(div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        sum_r[i] <= '0;
        bias_r[i] <= '0;
      end
      div_busy_d <= 1'b0;
    end else begin
      div_busy_d <= div_busy;
      if (cmd.acc_add) begin
        sum_r[0] <= sum_r[0] + 33'(in_data.gyro_x_raw);
        sum_r[1] <= sum_r[1] + 33'(in_data.gyro_y_raw);
        sum_r[2] <= sum_r[2] + 33'(in_data.gyro_z_raw);
      end
      // capture quotient as the divider finishes
      if (div_busy_d && !div_busy) bias_r[div_axis] <= div_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) item_r <= in_data;
  end

  // one shared multiplier, one axis per step
  always_comb begin
    case (axis_sel)
      3'd0: raw = item_r.accel_x_raw;
      3'd1: raw = item_r.accel_y_raw;
      3'd2: raw = item_r.accel_z_raw;
      3'd3: raw = item_r.gyro_x_raw;
      3'd4: raw = item_r.gyro_y_raw;
      default: raw = item_r.gyro_z_raw;
    endcase
    case (axis_sel)
      3'd3: bsel = bias_r[0];
      3'd4: bsel = bias_r[1];
      3'd5: bsel = bias_r[2];
      default: bsel = '0;
    endcase
    if (axis_sel < 3'd3) begin
      diff = 25'(raw);
      fac = {1'b0, accel_scale};
    end else begin
      diff = {raw[15], raw, 8'd0} - 25'(bsel);
      fac = {1'b0, gyro_scale};
    end
    prod = 42'(diff) * 42'(fac);
    if (axis_sel < 3'd3) rnd = (prod + 42'sd128) >>> 8;
    else rnd = (prod + 42'sd32768) >>> 16;
  end

  always_ff @(posedge clk) begin
    if (cmd.scale_step) scaled_r[axis_sel] <= rnd[31:0];
  end

  assign wentry = {item_r.stamp, scaled_r[0], scaled_r[1], scaled_r[2],
                   scaled_r[3], scaled_r[4], scaled_r[5]};

  ibc_ram #(.WIDTH(ENTRY_W), .DEPTH(RING_DEPTH)) u_ring (
    .clk(clk), .we(cmd.ring_write), .waddr(wr_idx[AW-1:0]), .wdata(wentry),
    .re(cmd.rd_issue), .raddr(rd_idx), .rdata(rentry)
  );

  assign rtime = rentry[ENTRY_W-1 -: 48];
  assign stat.rd_match = (rtime > item_r.window_start) && (rtime <= item_r.window_end);
  assign stat.div_busy = div_busy;

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_r.found <= 1'b1;
      res_r.last <= 1'b0;
      {res_r.sample_time, res_r.accel_x, res_r.accel_y, res_r.accel_z,
       res_r.gyro_x, res_r.gyro_y, res_r.gyro_z} <= rentry;
    end else if (cmd.res_empty) begin
      res_r <= {1'b0, 1'b1, {ENTRY_W{1'b0}}};
    end else if (cmd.res_last) begin
      res_r.last <= 1'b1;
    end
  end

  assign res = res_r;
endmodule

>>> sv/ibc_ctrl.sv
// Controller: sequences calibration, sample storage and ring queries
module ibc_ctrl #(
  parameter int RING_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  ibc_in_if.sink               in_ch,
  ibc_out_if.source            out_ch,
  ibc_cfg_if.sink              cfg_ch,
  input  ibc_pkg::ibc_stat_t   stat,
  output ibc_pkg::ibc_cmd_t    cmd,
  output logic [1:0]           div_axis,
  output logic [2:0]           axis_sel,
  output logic [$clog2(RING_DEPTH)-1:0] wr_idx,
  output logic [$clog2(RING_DEPTH)-1:0] rd_idx,
  output logic [15:0]          calib_seen,
  output logic [15:0]          accel_scale,
  output logic [15:0]          gyro_scale
);
  import ibc_pkg::*;
  localparam int AW = $clog2(RING_DEPTH);
  localparam int CW = $clog2(RING_DEPTH + 1);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DIV   = 9'b000000010,
    S_DWAIT = 9'b000000100,
    S_SCALE = 9'b000001000,
    S_WRITE = 9'b000010000,
    S_RD    = 9'b000100000,
    S_CHK   = 9'b001000000,
    S_OUT   = 9'b010000000,
    S_FLUSH = 9'b100000000
  } state_t;

  state_t          state_r, state_nxt;
  logic [15:0]     calib_samples_r, seen_r, seen_inc;
  logic [15:0]     accel_scale_r, gyro_scale_r;
  logic            calibrating_r;
  logic [AW-1:0]   wpos_r, rptr_r, rptr_nxt;
  logic [CW-1:0]   fill_r, left_r;
  logic [1:0]      dax_r;
  logic [2:0]      ax_r;
  logic            pend_r, store_after_r, held_r;
  logic            in_acc, out_acc;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;
  assign out_ch.valid = (state_r == S_OUT);
  assign cfg_ch.ready = 1'b1;
  assign seen_inc = seen_r + 16'd1;
  assign rptr_nxt = (rptr_r == AW'(RING_DEPTH - 1)) ? '0 : rptr_r + AW'(1);

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    cmd.load_in = in_acc;
    case (state_r)
      S_IDLE: if (in_acc) begin
        if (in_ch.data.func) begin
          if (calibrating_r || fill_r == '0) state_nxt = S_OUT;
          else state_nxt = S_RD;
          cmd.res_empty = 1'b1;
        end else if (calibrating_r && seen_r < calib_samples_r) begin
          cmd.acc_add = 1'b1;
          if (seen_inc >= calib_samples_r && seen_inc > 16'(MIN_CALIB_COUNT))
            state_nxt = S_DIV;
        end else if (calibrating_r && seen_r > 16'(MIN_CALIB_COUNT)) begin
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_SCALE;
        end
      end
      S_DIV: begin
        cmd.div_start = 1'b1;
        state_nxt = S_DWAIT;
      end
      S_DWAIT: if (!stat.div_busy) begin
        if (dax_r == 2'd2) state_nxt = store_after_r ? S_SCALE : S_IDLE;
        else state_nxt = S_DIV;
      end
      S_SCALE: begin
        cmd.scale_step = 1'b1;
        if (ax_r == 3'd5) state_nxt = S_WRITE;
      end
      S_WRITE: begin
        cmd.ring_write = 1'b1;
        state_nxt = S_IDLE;
      end
      S_RD: begin
        cmd.rd_issue = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (stat.rd_match) begin
          if (pend_r) state_nxt = S_OUT;
          else begin
            cmd.res_load = 1'b1;
            state_nxt = (left_r == '0) ? S_FLUSH : S_RD;
          end
        end else begin
          state_nxt = (left_r == '0) ? S_FLUSH : S_RD;
        end
      end
      S_OUT: if (out_acc) begin
        // a held match waits in the read register; load it next
        if (held_r) begin
          cmd.res_load = 1'b1;
          state_nxt = (left_r == '0) ? S_FLUSH : S_RD;
        end else state_nxt = S_IDLE;
      end
      S_FLUSH: begin
        if (!pend_r) cmd.res_empty = 1'b1;
        cmd.res_last = pend_r;
        state_nxt = S_OUT;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      calib_samples_r <= 16'd1000;
      accel_scale_r <= 16'd10042;
      gyro_scale_r <= 16'd8927;
      calibrating_r <= 1'b1;
      seen_r <= '0;
      wpos_r <= '0;
      fill_r <= '0;
      left_r <= '0;
      rptr_r <= '0;
      dax_r <= '0;
      ax_r <= '0;
      pend_r <= 1'b0;
      held_r <= 1'b0;
      store_after_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          CFG_CALIB: calib_samples_r <= cfg_ch.wdata;
          CFG_ACCEL: accel_scale_r <= cfg_ch.wdata;
          CFG_GYRO:  gyro_scale_r <= cfg_ch.wdata;
          default: ;
        endcase
      end
      if (state_r == S_IDLE && in_acc) begin
        dax_r <= '0;
        ax_r <= '0;
        pend_r <= 1'b0;
        if (in_ch.data.func) begin
          left_r <= fill_r;
          // oldest entry sits fill_r slots behind the write position
          if (CW'(wpos_r) >= fill_r) rptr_r <= AW'(CW'(wpos_r) - fill_r);
          else rptr_r <= AW'(CW'(wpos_r) + CW'(RING_DEPTH) - fill_r);
        end else if (calibrating_r && seen_r < calib_samples_r) begin
          seen_r <= seen_inc;
          store_after_r <= 1'b0;
          if (seen_inc >= calib_samples_r) calibrating_r <= 1'b0;
        end else begin
          store_after_r <= 1'b1;
          calibrating_r <= 1'b0;
        end
      end
      if (state_r == S_DWAIT && !stat.div_busy) dax_r <= dax_r + 2'd1;
      if (cmd.scale_step) ax_r <= ax_r + 3'd1;
      if (cmd.ring_write) begin
        wpos_r <= (wpos_r == AW'(RING_DEPTH - 1)) ? '0 : wpos_r + AW'(1);
        if (fill_r != CW'(RING_DEPTH)) fill_r <= fill_r + CW'(1);
      end
      if (cmd.rd_issue) begin
        rptr_r <= rptr_nxt;
        left_r <= left_r - CW'(1);
      end
      if (cmd.res_load) pend_r <= 1'b1;
      else if (state_r == S_OUT && out_acc) pend_r <= 1'b0;
      if (state_r == S_CHK && stat.rd_match && pend_r) held_r <= 1'b1;
      else if (state_r == S_OUT && out_acc) held_r <= 1'b0;
    end
  end

  assign div_axis = dax_r;
  assign axis_sel = ax_r;
  assign wr_idx = wpos_r;
  assign rd_idx = rptr_r;
  assign calib_seen = seen_r;
  assign accel_scale = accel_scale_r;
  assign gyro_scale = gyro_scale_r;

  `include "imu_bias_calibrate_scale_ring_unit_assert.svh"
  `IBC_ASSERT_IMPL(a_fill_bound, 1'b1, fill_r <= CW'(RING_DEPTH))
  `IBC_ASSERT_IMPL(a_no_write_in_query, cmd.ring_write, !cmd.rd_issue && !cmd.res_load)
  `IBC_ASSERT_NEXT(a_calib_stays_off, !calibrating_r, !calibrating_r)
endmodule

>>> sv/imu_bias_calibrate_scale_ring_unit.sv
// Top level: IMU gyro bias calibration, scaling and timestamped sample ring
//  channel | dir | handshake         | payload
//  in      | in  | in_valid/ready    | func, stamp, raw axes, window bounds
//  out     | out | out_valid/ready   | found, last, sample_time, scaled axes
//  cfg     | in  | cfg_valid/ready   | index, wdata (always ready)
// Sample during calibration: summed; the closing one adds 3 bias divisions.
// Stored sample: taken, scaled in 6 steps through the shared multiplier, then written to the ring.
// Query: each stored entry is read and checked, each result is output, then a flush ends the query.
// A stalled out side holds the walk; no input is taken until the query ends.
// Synchronous reset clears control state; ring contents are undefined until written.
module imu_bias_calibrate_scale_ring_unit #(
  parameter int RING_DEPTH = 64
) (
  input  logic clk,
  input  logic rst_n,
  ibc_in_if.sink    in_ch,
  ibc_out_if.source out_ch,
  ibc_cfg_if.sink   cfg_ch
);
  import ibc_pkg::*;
  localparam int AW = $clog2(RING_DEPTH);

  ibc_cmd_t  cmd;
  ibc_stat_t stat;
  logic [1:0]    div_axis;
  logic [2:0]    axis_sel;
  logic [AW-1:0] wr_idx, rd_idx;
  logic [15:0]   calib_seen, accel_scale, gyro_scale;

  ibc_ctrl #(.RING_DEPTH(RING_DEPTH)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .stat(stat), .cmd(cmd), .div_axis(div_axis), .axis_sel(axis_sel),
    .wr_idx(wr_idx), .rd_idx(rd_idx), .calib_seen(calib_seen),
    .accel_scale(accel_scale), .gyro_scale(gyro_scale)
  );

  ibc_datapath #(.RING_DEPTH(RING_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .div_axis(div_axis), .axis_sel(axis_sel),
    .wr_idx(wr_idx), .rd_idx(rd_idx), .in_data(in_ch.data), .calib_seen(calib_seen),
    .accel_scale(accel_scale), .gyro_scale(gyro_scale), .stat(stat), .res(out_ch.data)
  );
endmodule
